// ===== src/assert_macros.svh =====
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: property failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
	`ASSERT_CLK(name, clk, rst_n, !(cond))

`endif

// ===== src/tmc_pkg.sv =====
package tmc_pkg;

	localparam int PAGE_COUNT     = 17;
	localparam int PAGE_WORDS     = 4096;
	localparam int TILE_BANK_BITS = 8;
	localparam int VRAM_DEPTH     = PAGE_COUNT * PAGE_WORDS;
	localparam int VRAM_AW        = $clog2(VRAM_DEPTH);
	localparam int PAGE_AW        = $clog2(PAGE_WORDS);

	localparam logic [2:0] NO_OWNER = 3'd4;

	typedef logic [15:0][2:0] owner_map_t;

	typedef enum logic [3:0] {
		ACT_REG_WR  = 4'd0,
		ACT_REG_BW  = 4'd1,
		ACT_REG_RD  = 4'd2,
		ACT_TILE_BK = 4'd3,
		ACT_LOOKUP  = 4'd4,
		ACT_VRAM_WR = 4'd5,
		ACT_VRAM_RD = 4'd6,
		ACT_VRAM_BW = 4'd7,
		ACT_VRAM_BR = 4'd8
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POST,
		ST_VRD,
		ST_LAYOUT,
		ST_MOD,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic               en;
		logic               we;
		logic [VRAM_AW-1:0] addr;
		logic [15:0]        wdata;
	} vram_req_t;

	localparam logic [4:0] REG_CTRL   = 5'h00;
	localparam logic [4:0] REG_MODE   = 5'h04;
	localparam logic [4:0] REG_PAGE   = 5'h19;
	localparam logic [4:0] REG_BANK_L = 5'h1a;
	localparam logic [4:0] REG_BANK_H = 5'h1b;
	localparam logic [4:0] REG_LOOKUP = 5'h1c;
	localparam logic [4:0] REG_IRQ    = 5'h03;

endpackage

// ===== src/tmc_vram.sv =====
module tmc_vram (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tmc_pkg::vram_req_t       req,
	output logic [15:0]              rdata,
	output logic                     clearing
);
	import tmc_pkg::*;

	logic [15:0]        mem [VRAM_DEPTH];
	logic [VRAM_AW-1:0] clr_addr_q;
	logic               clr_busy_q;

	// clear sweep, one word per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_addr_q == VRAM_AW'(VRAM_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (req.en && req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.en && !req.we) begin
			rdata <= mem[req.addr];
		end
	end

	assign clearing = clr_busy_q;

endmodule

// ===== src/tmc_layout.sv =====
module tmc_layout (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            layer_sel,
	input  logic                  assoc_dflt,
	input  logic [7:0][4:0]       geom,
	output tmc_pkg::owner_map_t   owner_map,
	output logic                  assoc_new,
	output logic                  busy
);
	import tmc_pkg::*;

	owner_map_t owner_q;
	logic [1:0] lyr_q;
	logic       busy_q;
	logic [1:0] y, x, h, w;
	logic [2:0] who;
	logic       full_map;
	logic [1:0] dr, dc;
	owner_map_t owner_nx;

	// any layer spanning the whole 4x4 map disables association
	always_comb begin
		full_map = 1'b0;
		for (int l = 0; l < 4; l++) begin
			if (geom[l][4:3] == 2'd0 && geom[l+4][4:3] == 2'd0 &&
			    geom[l][1:0] == 2'd3 && geom[l+4][1:0] == 2'd3) begin
				full_map = 1'b1;
			end
		end
		assoc_new = assoc_dflt && !full_map;
	end

	always_comb begin
		y        = geom[lyr_q][4:3];
		h        = geom[lyr_q][1:0];
		x        = geom[lyr_q + 3'd4][4:3];
		w        = geom[lyr_q + 3'd4][1:0];
		who      = assoc_new ? {1'b0, lyr_q} : {1'b0, layer_sel};
		owner_nx = owner_q;
		dr       = '0;
		dc       = '0;
		for (int p = 0; p < 16; p++) begin
			dr = 2'(p >> 2) - y;
			dc = 2'(p) - x;
			if (dr <= h && dc <= w && owner_q[p] == NO_OWNER) begin
				owner_nx[p] = who;
			end
		end
	end

	// one layer claimed per cycle, lowest layer first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= '0;
			lyr_q   <= '0;
			busy_q  <= 1'b0;
		end else if (start) begin
			owner_q <= {16{NO_OWNER}};
			lyr_q   <= '0;
			busy_q  <= 1'b1;
		end else if (busy_q) begin
			owner_q <= owner_nx;
			lyr_q   <= lyr_q + 1'b1;
			if (lyr_q == 2'd3) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign owner_map = owner_q;
	assign busy      = busy_q;

endmodule

// ===== src/tmc_bankmod.sv =====
module tmc_bankmod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [12:0] bank_count,
	output logic [11:0] bank,
	output logic        busy
);
	import tmc_pkg::*;

	logic [31:0] div_q;
	logic [12:0] n_q;
	logic [12:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [11:0] bank_q;
	logic [12:0] n_eff;
	logic [13:0] trial;
	logic [13:0] diff;
	logic [12:0] rem_nx;

	assign n_eff = (bank_count > 13'h1000) ? 13'h1000 : bank_count;

	// restoring remainder, one dividend bit per cycle
	always_comb begin
		trial  = {rem_q, div_q[31]};
		diff   = trial - {1'b0, n_q};
		rem_nx = (trial >= {1'b0, n_q}) ? diff[12:0] : trial[12:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bank_q <= '0;
			cnt_q  <= '0;
		end else if (start) begin
			if (n_eff == '0) begin
				bank_q <= '0;
			end else begin
				busy_q <= 1'b1;
			end
			cnt_q <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				bank_q <= rem_nx[11:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			n_q   <= n_eff;
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= {div_q[30:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	assign bank = bank_q;
	assign busy = busy_q;

endmodule

// ===== src/tilemap_control_registers.sv =====
// Control registers and page-mapped VRAM of a tilemap controller. Each input
// word is one bus access (register write/read, tile bank set, nibble lookup,
// VRAM word or byte access through the selected page) and yields exactly one
// output word with the read data and a snapshot of the control state. Items
// are handled one at a time. Register reads, lookups, VRAM word writes and
// unused actions pass from EXEC straight to OUT; other register writes add
// POST, VRAM word reads and byte accesses add VRD. Layout register writes
// then walk the layers in LAYOUT (one layer per cycle), and bank register
// writes and tile bank sets run MOD (one bit per cycle of a 32-bit
// remainder by the bank count). The next access can be taken in the cycle
// after the word is loaded into the output register, so it is taken while
// that word waits. A stalled output only holds the block once a second
// word is ready. After reset the VRAM (69632 words) is cleared one word a
// cycle, and s_tready stays low until the clear is done. Config writes are
// taken whenever no access is in flight, including during the clear.
module tilemap_control_registers (
	input  logic         clk,
	input  logic         arst_n,
	// config write: cfg_index 0 default_layer_assoc, 1 gfx_bank_count
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [12:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,  // [12:0] address, [28:13] data, rest zero
	input  logic [3:0]   s_tuser,  // [3:0] action
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] read_data, [16] irq_enabled, [17] flip_x, [18] flip_y,
	// [23:19] ram_page, [35:24] gfx_bank, [36] assoc_on, [38:37] current_layer,
	// [86:39] page_layer_map, [102:87] page_mode_bits, [103] zero
	output logic [103:0] m_tdata
);
	import tmc_pkg::*;

	st_t         st_q, st_nx;
	act_t        act_q;
	logic [12:0] addr_q;
	logic [15:0] data_q;
	logic [15:0] rd_q;

	logic [15:0] ctrl_q [32];
	logic [3:0]  lmode_q;
	logic [15:0] pmode_q;
	logic        assoc_q;
	logic        assoc_dflt_q;
	logic [12:0] bank_cnt_q;
	logic [1:0]  lsel_q;
	logic [4:0]  page_q;
	logic [1:0]  flip_q;
	logic [7:0]  tile_q;
	logic        tile_used_q;

	logic        out_valid_q;
	logic [103:0] out_q;

	logic [4:0]  ridx;
	logic        hi;
	logic [15:0] wv;
	logic [15:0] vram_rd;
	logic        clearing;
	vram_req_t   vreq;
	logic        lay_start, lay_busy, lay_assoc;
	owner_map_t  owners;
	logic [7:0][4:0] geom;
	logic        mod_start, mod_busy;
	logic [11:0] bank;
	logic [31:0] bank_src;
	logic [4:0]  page_nx;
	logic        out_free;
	logic [15:0] lookup;

	assign ridx = addr_q[5:1];
	assign hi   = !addr_q[0];   // even address is the high byte

	// word or byte merge for register writes
	always_comb begin
		wv = data_q;
		if (act_q == ACT_REG_BW) begin
			wv = hi ? {data_q[7:0], ctrl_q[ridx][7:0]} : {ctrl_q[ridx][15:8], data_q[7:0]};
		end
	end

	always_comb begin
		for (int l = 0; l < 8; l++) begin
			geom[l] = ctrl_q[8 + l][4:0];
		end
	end

	always_comb begin
		if (tile_used_q) begin
			bank_src = {24'd0, ctrl_q[REG_BANK_L][15:8]} | {12'd0, ctrl_q[REG_BANK_H], 4'd0}
			         | {18'd0, tile_q, 6'd0};
		end else begin
			bank_src = {ctrl_q[REG_BANK_H], ctrl_q[REG_BANK_L]};
		end
	end

	// page 16 is the line scroll page
	assign page_nx = ctrl_q[REG_CTRL][1] ? 5'd16 :
	                 {1'b0, ctrl_q[REG_PAGE][4:3], ctrl_q[REG_PAGE][1:0]};

	always_comb begin
		lookup = {12'd0, 4'(ctrl_q[REG_LOOKUP] >> {data_q[1:0], 2'b00})};
		if (tile_used_q) begin
			lookup = lookup | {4'd0, tile_q, 4'd0};
		end
	end

	// page modes follow the owning layer; unowned pages keep theirs
	function automatic logic [15:0] refresh_modes(input logic [15:0] cur,
	                                              input owner_map_t own,
	                                              input logic [3:0] lm);
		logic [15:0] r;
		r = cur;
		for (int i = 0; i < 16; i++) begin
			if (own[i] < NO_OWNER) begin
				r[i] = lm[own[i][1:0]];
			end
		end
		return r;
	endfunction

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		st_nx     = st_q;
		vreq      = '0;
		vreq.addr = {page_q, addr_q[PAGE_AW:1]};
		lay_start = 1'b0;
		mod_start = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (s_tvalid && s_tready) begin
					st_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				st_nx = ST_OUT;
				case (act_q)
					ACT_REG_WR, ACT_REG_BW, ACT_TILE_BK: st_nx = ST_POST;
					ACT_VRAM_WR: begin
						vreq.en    = 1'b1;
						vreq.we    = 1'b1;
						vreq.wdata = data_q;
					end
					ACT_VRAM_RD, ACT_VRAM_BW, ACT_VRAM_BR: begin
						vreq.en = 1'b1;
						st_nx   = ST_VRD;
					end
					default: ;
				endcase
			end
			ST_POST: begin
				st_nx = ST_OUT;
				if (act_q == ACT_TILE_BK) begin
					mod_start = 1'b1;
					st_nx     = ST_MOD;
				end else if (ridx inside {[5'd8:5'd15]}) begin
					lay_start = 1'b1;
					st_nx     = ST_LAYOUT;
				end else if (ridx == REG_BANK_L || ridx == REG_BANK_H) begin
					mod_start = 1'b1;
					st_nx     = ST_MOD;
				end
			end
			ST_VRD: begin
				st_nx = ST_OUT;
				if (act_q == ACT_VRAM_BW) begin
					vreq.en    = 1'b1;
					vreq.we    = 1'b1;
					vreq.wdata = hi ? {data_q[7:0], vram_rd[7:0]} : {vram_rd[15:8], data_q[7:0]};
				end
			end
			ST_LAYOUT: begin
				if (!lay_busy) begin
					st_nx = ST_OUT;
				end
			end
			ST_MOD: begin
				if (!mod_busy) begin
					st_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					st_nx = ST_IDLE;
				end
			end
			default: st_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

	// item capture and read data
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && s_tvalid && s_tready) begin
			act_q  <= act_t'(s_tuser);
			addr_q <= s_tdata[12:0];
			data_q <= s_tdata[28:13];
			rd_q   <= '0;
		end else if (st_q == ST_EXEC) begin
			if (act_q == ACT_REG_RD) begin
				rd_q <= ctrl_q[ridx];
			end else if (act_q == ACT_LOOKUP) begin
				rd_q <= lookup;
			end
		end else if (st_q == ST_VRD) begin
			if (act_q == ACT_VRAM_RD) begin
				rd_q <= vram_rd;
			end else if (act_q == ACT_VRAM_BR) begin
				rd_q <= hi ? {8'd0, vram_rd[15:8]} : {8'd0, vram_rd[7:0]};
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) begin
				ctrl_q[i] <= '0;
			end
			lmode_q      <= '1;
			pmode_q      <= '1;
			assoc_q      <= 1'b1;
			assoc_dflt_q <= 1'b1;
			bank_cnt_q   <= 13'd1;
			lsel_q       <= '0;
			page_q       <= '0;
			flip_q       <= '0;
			tile_q       <= '0;
			tile_used_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == 1'b0) begin
					assoc_dflt_q <= cfg_data[0];
					assoc_q      <= cfg_data[0];
				end else begin
					bank_cnt_q <= cfg_data;
				end
			end
			case (st_q)
				ST_EXEC: begin
					if (act_q == ACT_REG_WR || act_q == ACT_REG_BW) begin
						ctrl_q[ridx] <= wv;
					end else if (act_q == ACT_TILE_BK) begin
						tile_used_q <= 1'b1;
						tile_q      <= data_q[TILE_BANK_BITS-1:0];
					end
				end
				ST_POST: begin
					if (act_q != ACT_TILE_BK) begin
						if (ridx inside {[5'd8:5'd15]}) begin
							lsel_q  <= ridx[1:0];
							assoc_q <= lay_assoc;
						end else if (ridx == REG_CTRL) begin
							flip_q  <= {ctrl_q[REG_CTRL][5], ctrl_q[REG_CTRL][4]};
							page_q  <= page_nx;
							pmode_q <= refresh_modes(pmode_q, owners, lmode_q);
						end else if (ridx == REG_PAGE) begin
							page_q  <= page_nx;
							pmode_q <= refresh_modes(pmode_q, owners, lmode_q);
						end else if (ridx == REG_MODE) begin
							lmode_q <= ctrl_q[REG_MODE][3:0];
							pmode_q <= refresh_modes(pmode_q, owners, ctrl_q[REG_MODE][3:0]);
						end
					end
				end
				ST_LAYOUT: begin
					if (!lay_busy) begin
						pmode_q <= refresh_modes(pmode_q, owners, lmode_q);
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && out_free) begin
			out_q <= {1'b0, pmode_q, owners, lsel_q, assoc_q, bank, page_q,
			          flip_q[1], flip_q[0], ctrl_q[REG_IRQ][0], rd_q};
		end
	end

	tmc_vram u_vram (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (vreq),
		.rdata    (vram_rd),
		.clearing (clearing)
	);

	tmc_layout u_layout (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (lay_start),
		.layer_sel  (lsel_q),
		.assoc_dflt (assoc_dflt_q),
		.geom       (geom),
		.owner_map  (owners),
		.assoc_new  (lay_assoc),
		.busy       (lay_busy)
	);

	tmc_bankmod u_bankmod (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (mod_start),
		.dividend   (bank_src),
		.bank_count (bank_cnt_q),
		.bank       (bank),
		.busy       (mod_busy)
	);

	// config only between accesses, so it never races the access state
	assign cfg_ready = (st_q == ST_IDLE);
	assign s_tready  = (st_q == ST_IDLE) && !clearing;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

endmodule

// ===== src/tmc_checker.sv =====
module tmc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata
);
	`include "assert_macros.svh"

	// a held result stays offered
	`ASSERT_CLK(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid)
	// one access at a time: busy right after an accept
	`ASSERT_CLK(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready |=> !s_tready)
	// no result can appear in the cycle after an accept from idle output
	`ASSERT_CLK(a_no_instant, clk, arst_n, s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
	// ram page never beyond the line scroll page
	`ASSERT_NEVER(a_page_range, clk, arst_n, m_tvalid && m_tdata[23] && m_tdata[22:19] != 4'd0)

endmodule

bind tilemap_control_registers tmc_checker u_tmc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
